@@ src/fbps_pkg.sv @@
`default_nettype none
package fbps_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam int TIME_W = 32;
	localparam int SVC_W = 16;
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture a new item
		logic pop;     // retire the oldest ring entry
		logic commit;  // decide accept or drop, write the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_ok;  // oldest entry finishes at or before the arrival
	} status_t;

endpackage
`default_nettype wire

@@ src/fbps_ctrl.sv @@
`default_nettype none
module fbps_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire fbps_pkg::status_t sts,
	output fbps_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_RETIRE = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_RETIRE: begin
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
				end else if (out_free) begin
					cmd.commit = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_RETIRE;
				end
				S_RETIRE: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && cmd.commit))
		else $error("pop and commit in the same cycle");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit would overwrite a pending result");

	a_accept_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_RETIRE && !in_stall == 1'b0))
		else $error("accepted item did not enter retirement");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (out_valid_q && state_q == S_IDLE))
		else $error("commit did not present a result");

endmodule
`default_nettype wire

@@ src/fbps_dp.sv @@
`default_nettype none
module fbps_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fbps_pkg::cmd_t                  cmd,
	output fbps_pkg::status_t                    sts,
	input  wire logic                            cfg_we,
	input  wire logic [fbps_pkg::LIMIT_W-1:0]    cfg_limit,
	input  wire logic [fbps_pkg::TIME_W-1:0]     arrival_tick,
	input  wire logic [fbps_pkg::SVC_W-1:0]      service_time,
	output logic                                 dropped,
	output logic [fbps_pkg::TIME_W-1:0]          start_tick
);

	logic [fbps_pkg::TIME_W-1:0]  ring_q [fbps_pkg::BUFFER_DEPTH];
	logic [fbps_pkg::IDX_W-1:0]   head_q;
	logic [fbps_pkg::CNT_W-1:0]   count_q;
	logic [fbps_pkg::TIME_W-1:0]  last_finish_q;
	logic [fbps_pkg::LIMIT_W-1:0] limit_q;
	logic [fbps_pkg::TIME_W-1:0]  arrival_q;
	logic [fbps_pkg::SVC_W-1:0]   service_q;
	logic                         dropped_q;
	logic [fbps_pkg::TIME_W-1:0]  start_q;

	logic                         full;
	logic [fbps_pkg::TIME_W-1:0]  start_c;
	logic [fbps_pkg::TIME_W:0]    finish_sum;
	logic [fbps_pkg::TIME_W-1:0]  finish_c;
	logic [fbps_pkg::SUM_W-1:0]   tail_sum;
	logic [fbps_pkg::SUM_W-1:0]   tail_wrap;
	logic [fbps_pkg::IDX_W-1:0]   tail_idx;
	logic [fbps_pkg::IDX_W-1:0]   head_next;

	assign sts.pop_ok = (count_q != '0) && (ring_q[head_q] <= arrival_q);

	// count never exceeds the depth, so this also caps the limit at the depth
	assign full = (32'(count_q) >= 32'(limit_q)) ||
		(32'(count_q) >= 32'(fbps_pkg::BUFFER_DEPTH));

	assign start_c    = (arrival_q > last_finish_q) ? arrival_q : last_finish_q;
	assign finish_sum = {1'b0, start_c} + (fbps_pkg::TIME_W + 1)'(service_q);
	assign finish_c   = finish_sum[fbps_pkg::TIME_W] ? '1 : finish_sum[fbps_pkg::TIME_W-1:0];

	assign tail_sum  = fbps_pkg::SUM_W'(head_q) + fbps_pkg::SUM_W'(count_q);
	assign tail_wrap = (tail_sum >= fbps_pkg::SUM_W'(fbps_pkg::BUFFER_DEPTH)) ?
		tail_sum - fbps_pkg::SUM_W'(fbps_pkg::BUFFER_DEPTH) : tail_sum;
	assign tail_idx  = tail_wrap[fbps_pkg::IDX_W-1:0];

	assign head_next = (32'(head_q) == 32'(fbps_pkg::BUFFER_DEPTH - 1)) ?
		'0 : head_q + fbps_pkg::IDX_W'(1);

	assign dropped    = dropped_q;
	assign start_tick = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			last_finish_q <= '0;
			limit_q       <= fbps_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we) limit_q <= cfg_limit;
			if (cmd.pop) begin
				head_q  <= head_next;
				count_q <= count_q - fbps_pkg::CNT_W'(1);
			end else if (cmd.commit && !full) begin
				count_q       <= count_q + fbps_pkg::CNT_W'(1);
				last_finish_q <= finish_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arrival_q <= arrival_tick;
			service_q <= service_time;
		end
		if (cmd.commit) begin
			dropped_q <= full;
			start_q   <= full ? '0 : start_c;
			if (!full) ring_q[tail_idx] <= finish_c;
		end
	end

endmodule
`default_nettype wire

@@ src/finite_buffer_packet_scheduler.sv @@
// Flow: an accepted item is captured, then the ring entries that finish at or
//   before its arrival retire one per cycle, then the item is decided and its
//   result registered; a held result that stalls the output delays the decision.
//   A new item is taken only once the previous one has been decided.
// Reset: arst_n clears the ring (head, count), last finish time and output
//   valid, and loads a buffer limit of 16.
`default_nettype none
module finite_buffer_packet_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input items
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [fbps_pkg::TIME_W-1:0]   arrival_tick,
	input  wire logic [fbps_pkg::SVC_W-1:0]    service_time,
	// result items
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               dropped,
	output logic [fbps_pkg::TIME_W-1:0]        start_tick,
	// buffer limit register
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [fbps_pkg::LIMIT_W-1:0]  buffer_limit
);

	fbps_pkg::cmd_t    cmd;
	fbps_pkg::status_t sts;

	// Always ready. Writes must come only while idle; the block does not check.
	assign cfg_ready = 1'b1;

	// Sequence each item: capture it, retire expired entries one per cycle,
	// then decide and hold the result in the output register.
	fbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the finish-time ring, the last finish time and the result register.
	fbps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_limit    (buffer_limit),
		.arrival_tick (arrival_tick),
		.service_time (service_time),
		.dropped      (dropped),
		.start_tick   (start_tick)
	);

endmodule
`default_nettype wire

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// generous bound: every item retiring a full ring, idles, stalls and holds
	localparam int CYCLE_LIMIT   = 300000;
	// results wait on the retirements, so allow a full ring plus margin
	localparam int SETTLE_CYCLES = 2 + fbps_pkg::BUFFER_DEPTH + 8;
	localparam int IDLE_PCT      = 18;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_CYCLES   = 250;

	typedef struct packed {
		logic                        dropped;
		logic [fbps_pkg::TIME_W-1:0] start_tick;
	} sched_result_t;

	// block ports
	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [fbps_pkg::TIME_W-1:0]  arrival_tick = '0;
	logic [fbps_pkg::SVC_W-1:0]   service_time = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic                         dropped;
	logic [fbps_pkg::TIME_W-1:0]  start_tick;
	logic                         cfg_valid    = 1'b0;
	logic                         cfg_ready;
	logic [fbps_pkg::LIMIT_W-1:0] buffer_limit = '0;

	// scheduler shadow state: ring of finish times, oldest at sched_head
	logic [fbps_pkg::TIME_W-1:0]  sched_finish [fbps_pkg::BUFFER_DEPTH];
	logic [fbps_pkg::IDX_W-1:0]   sched_head        = '0;
	logic [fbps_pkg::CNT_W-1:0]   sched_count       = '0;
	logic [fbps_pkg::TIME_W-1:0]  sched_last_finish = '0;
	logic [fbps_pkg::LIMIT_W-1:0] sched_limit       = fbps_pkg::LIMIT_RESET;

	// outcomes of accepted packets, oldest first
	sched_result_t pending_results [$];

	// current tick of the arrival stream
	logic [fbps_pkg::TIME_W-1:0] now = '0;

	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	int hold_request = 0;
	int hold_left    = 0;
	int error_count  = 0;
	int cycle_count  = 0;

	finite_buffer_packet_scheduler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.arrival_tick (arrival_tick),
		.service_time (service_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dropped      (dropped),
		.start_tick   (start_tick),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.buffer_limit (buffer_limit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Retire expired entries, then accept or tail-drop the packet.
	task automatic schedule_packet(input logic [fbps_pkg::TIME_W-1:0] arr,
			input logic [fbps_pkg::SVC_W-1:0] svc, output sched_result_t res);
		int                          lim;
		int                          slot;
		logic [fbps_pkg::TIME_W:0]   sum;
		logic [fbps_pkg::TIME_W-1:0] begin_tick;
		logic [fbps_pkg::TIME_W-1:0] finish;
		lim = (int'(sched_limit) > fbps_pkg::BUFFER_DEPTH) ?
			fbps_pkg::BUFFER_DEPTH : int'(sched_limit);
		// drop every front entry that is done by the time this packet shows up
		while (sched_count > 0 && sched_finish[sched_head] <= arr) begin
			sched_head  = (int'(sched_head) == fbps_pkg::BUFFER_DEPTH - 1) ?
				'0 : sched_head + fbps_pkg::IDX_W'(1);
			sched_count = sched_count - fbps_pkg::CNT_W'(1);
		end
		if (int'(sched_count) >= lim) begin
			res.dropped    = 1'b1;
			res.start_tick = '0;
		end else begin
			begin_tick = (arr > sched_last_finish) ? arr : sched_last_finish;
			sum        = {1'b0, begin_tick} + (fbps_pkg::TIME_W + 1)'(svc);
			// saturate the finish time on overflow
			finish     = sum[fbps_pkg::TIME_W] ? '1 : sum[fbps_pkg::TIME_W-1:0];
			slot       = (int'(sched_head) + int'(sched_count)) % fbps_pkg::BUFFER_DEPTH;
			sched_finish[fbps_pkg::IDX_W'(slot)] = finish;
			sched_count       = sched_count + fbps_pkg::CNT_W'(1);
			sched_last_finish = finish;
			res.dropped    = 1'b0;
			res.start_tick = begin_tick;
		end
	endtask

	// Offer one packet, hold it until accepted, then record its outcome.
	task automatic send_packet(input logic [fbps_pkg::TIME_W-1:0] arr,
			input logic [fbps_pkg::SVC_W-1:0] svc);
		sched_result_t res;
		while (send_idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		arrival_tick <= arr;
		service_time <= svc;
		do @(posedge clk); while (in_stall);
		schedule_packet(arr, svc, res);
		pending_results = {pending_results, res};
	endtask

	// Stop offering, wait out every outcome, then let the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [fbps_pkg::LIMIT_W-1:0] value);
		wait_drained();
		cfg_valid    <= 1'b1;
		buffer_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		sched_limit  = value;
	endtask

	// Mostly in-order arrivals with small gaps so the buffer fills; a few jump
	// far ahead to clear the backlog, a few go backwards.
	task automatic send_random_packet();
		int                          pick;
		logic [fbps_pkg::TIME_W-1:0] arr;
		logic [fbps_pkg::SVC_W-1:0]  svc;
		pick = $urandom_range(99, 0);
		if (pick < 5) begin
			arr = $urandom_range(now, 0);
		end else begin
			if (pick < 12)
				now = now + $urandom_range(32'h0002_0000, 0);
			else
				now = now + $urandom_range(40, 0);
			arr = now;
		end
		if ($urandom_range(99, 0) < 5)
			svc = fbps_pkg::SVC_W'($urandom_range(16'hFFFF, 0));
		else
			svc = fbps_pkg::SVC_W'($urandom_range(80, 0));
		send_packet(arr, svc);
	endtask

	task automatic report_error(input string what, input sched_result_t want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s: expected dropped=%0b start=%0d, got dropped=%0b start=%0d",
				$realtime, what, want.dropped, want.start_tick, dropped, start_tick);
	endtask

	// Check each result as it leaves.
	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					want = '0;
					report_error("result with nothing pending", want);
				end else begin
					want = pending_results.pop_front();
					if (dropped !== want.dropped || start_tick !== want.start_tick)
						report_error("mismatch", want);
				end
			end
		end
	end

	// Drive the output stall: random idling, or a long hold counted here.
	always @(posedge clk) begin : recv_pace
		if (arst_n) begin
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= recv_idle_on && ($urandom_range(99, 0) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Reset limit of 16: zero service, queueing behind the last finish, max service.
	task automatic test_default_limit();
		now = '0;
		send_packet(now, '0);
		send_packet(now, '0);
		send_packet(now + 5, 16'd10);
		send_packet(now + 6, 16'd20);
		send_packet(now + 7, '1);
		now = now + 7;
	endtask

	// Limit of one and three: the packet past the limit is dropped.
	task automatic test_tail_drop();
		write_limit(fbps_pkg::LIMIT_W'(1));
		now = 32'd65570;
		send_packet(now, 16'd4);
		send_packet(now, 16'd4);
		send_packet(now, 16'd4);
		send_packet(now + 4, 16'd1);
		write_limit(fbps_pkg::LIMIT_W'(3));
		now = 32'd70000;
		repeat (4) send_packet(now, 16'd50);
	endtask

	// Limit of zero: every packet is dropped.
	task automatic test_zero_limit();
		write_limit('0);
		now = now + 1000;
		send_packet(now, '0);
		send_packet(now, '1);
	endtask

	// Largest register value: the effective limit is the ring depth.
	task automatic test_limit_above_depth();
		write_limit('1);
		now = now + 100;
		repeat (4) send_packet(now, 16'd100);
	endtask

	// Lower the limit below the occupancy; drops last until entries retire.
	task automatic test_limit_below_count();
		write_limit(fbps_pkg::LIMIT_W'(2));
		send_packet(now, 16'd1);
		send_packet(now + 150, 16'd1);
		send_packet(now + 300, 16'd5);
		now = now + 300;
	endtask

	// Arrivals that go backwards follow the same rules.
	task automatic test_arrival_backwards();
		write_limit(fbps_pkg::LIMIT_W'(16));
		send_packet(now - 50, 16'd7);
		send_packet(now - 5000, 16'd3);
	endtask

	// Random traffic under a range of limits, each phase higher up the tick range.
	task automatic test_random_limits();
		int limits [8] = '{16, 1, 5, 31, 2, 0, 9, 16};
		for (int p = 0; p < 8; p++) begin
			write_limit(fbps_pkg::LIMIT_W'(limits[p]));
			now = now + $urandom_range(32'h1600_0000, 32'h1000_0000);
			repeat ((limits[p] == 0) ? 20 : 60) send_random_packet();
		end
	endtask

	// Back-to-back on both sides, no idling at all.
	task automatic test_quiet_stretch();
		write_limit(fbps_pkg::LIMIT_W'(8));
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		now = now + $urandom_range(32'h1600_0000, 32'h1000_0000);
		repeat (50) send_random_packet();
		wait_drained();
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// Hold the output off for a long stretch while packets keep coming.
	task automatic test_backpressure();
		write_limit(fbps_pkg::LIMIT_W'(16));
		hold_request = HOLD_CYCLES;
		repeat (40) begin
			now = now + $urandom_range(3, 0);
			send_packet(now, fbps_pkg::SVC_W'($urandom_range(30, 0)));
		end
	endtask

	// Finish times saturate at the top of the tick range. Run last: the
	// saturated last finish pins every later start at the maximum.
	task automatic test_finish_saturation();
		write_limit(fbps_pkg::LIMIT_W'(16));
		send_packet(32'hFFFF_FF00, '1);
		send_packet(32'hFFFF_FFF0, 16'd10);
		send_packet('1, '0);
		send_packet('1, '1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_limit();
		test_tail_drop();
		test_zero_limit();
		test_limit_above_depth();
		test_limit_below_count();
		test_arrival_backwards();
		test_random_limits();
		test_quiet_stretch();
		test_backpressure();
		test_finish_saturation();
		wait_drained();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
